// ===== rtl/apbt_pkg.sv =====
// shared types and constants for the affine pixel-pair binary test block
// no dependencies; every other file imports this package
package apbt_pkg;

    // build defaults and field widths
    localparam int IMAGE_WORDS_DEF = 65536;
    localparam int PIX_W           = 8;
    localparam int WADDR_W         = 16;
    localparam int CODE_W          = 32;
    localparam int GAIN_W          = 24;
    localparam int PITCH_W         = 13;
    localparam int CFG_IDX_W       = 4;
    localparam int CFG_DATA_W      = 24;
    localparam int FIXED_SHIFT     = 8;

    localparam logic [PITCH_W-1:0] ROW_PITCH_RESET = 13'd256;

    // item kinds
    localparam logic ACTION_WRITE = 1'b0;
    localparam logic ACTION_TEST  = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD  = 4'd0,
        REG_ROW_GAIN_A = 4'd1,
        REG_ROW_GAIN_B = 4'd2,
        REG_ROW_OFFSET = 4'd3,
        REG_COL_GAIN_A = 4'd4,
        REG_COL_GAIN_B = 4'd5,
        REG_COL_OFFSET = 4'd6,
        REG_ROW_PITCH  = 4'd7
    } t_reg_idx;

    // current configuration
    typedef struct packed {
        logic        [PIX_W-1:0]   threshold;
        logic signed [GAIN_W-1:0]  row_gain_a;
        logic signed [GAIN_W-1:0]  row_gain_b;
        logic signed [GAIN_W-1:0]  row_offset;
        logic signed [GAIN_W-1:0]  col_gain_a;
        logic signed [GAIN_W-1:0]  col_gain_b;
        logic signed [GAIN_W-1:0]  col_offset;
        logic        [PITCH_W-1:0] row_pitch;
    } t_cfg;

    // load enables of the coordinate mapping stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_map_ld;

    // pixel write payload carried down the pipeline
    typedef struct packed {
        logic               action;
        logic [WADDR_W-1:0] addr;
        logic [PIX_W-1:0]   value;
    } t_wr_beat;

endpackage

// ===== rtl/apbt_ifs.sv =====
// valid/ready channel interfaces: input items, results, configuration writes
// depends on apbt_pkg
interface apbt_item_if import apbt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               action;
    logic [WADDR_W-1:0] pixel_address;
    logic [PIX_W-1:0]   pixel_value;
    logic [CODE_W-1:0]  test_code;

    modport source (output valid, action, pixel_address, pixel_value, test_code,
                    input ready);
    modport sink   (input valid, action, pixel_address, pixel_value, test_code,
                    output ready);
endinterface

interface apbt_result_if import apbt_pkg::*; ();
    logic valid;
    logic ready;
    logic test_result;
    logic out_of_range;

    modport source (output valid, test_result, out_of_range, input ready);
    modport sink   (input valid, test_result, out_of_range, output ready);
endinterface

interface apbt_cfg_if import apbt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/apbt_cfg.sv =====
// configuration register file, written through the config channel
// depends on apbt_pkg and apbt_cfg_if
module apbt_cfg import apbt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    apbt_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // writes are always taken
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register decode, unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_THRESHOLD:  n_cfg.threshold  = i_cfg.data[PIX_W-1:0];
                REG_ROW_GAIN_A: n_cfg.row_gain_a = i_cfg.data;
                REG_ROW_GAIN_B: n_cfg.row_gain_b = i_cfg.data;
                REG_ROW_OFFSET: n_cfg.row_offset = i_cfg.data;
                REG_COL_GAIN_A: n_cfg.col_gain_a = i_cfg.data;
                REG_COL_GAIN_B: n_cfg.col_gain_b = i_cfg.data;
                REG_COL_OFFSET: n_cfg.col_offset = i_cfg.data;
                REG_ROW_PITCH:  n_cfg.row_pitch  = i_cfg.data[PITCH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg           <= '0;
            r_cfg.row_pitch <= ROW_PITCH_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== rtl/apbt_point_map.sv =====
// five-stage affine map of one code point to a store address with range check
// depends on apbt_pkg
module apbt_point_map import apbt_pkg::*; #(
    parameter  int IMAGE_WORDS = IMAGE_WORDS_DEF,
    localparam int AW          = $clog2(IMAGE_WORDS)
) (
    input  logic          i_clk,
    input  t_map_ld       i_ld,
    input  t_cfg          i_cfg,
    input  logic [7:0]    i_byte_a,
    input  logic [7:0]    i_byte_b,
    output logic [AW-1:0] o_addr,
    output logic          o_oor
);

    localparam int PROD_W = GAIN_W + 8;
    localparam int SUM_W  = PROD_W + 1;
    localparam int Q_W    = SUM_W - FIXED_SHIFT;
    localparam int RC_W   = Q_W - 1;
    localparam int RP_W   = RC_W + PITCH_W;
    localparam int AD_W   = RP_W + 1;

    // stage 1: gain products
    logic signed [PROD_W-1:0] n_p_ra, n_p_rb, n_p_ca, n_p_cb;
    logic signed [PROD_W-1:0] r_p_ra, r_p_rb, r_p_ca, r_p_cb;

    assign n_p_ra = $signed(i_cfg.row_gain_a) * $signed(i_byte_a);
    assign n_p_rb = $signed(i_cfg.row_gain_b) * $signed(i_byte_b);
    assign n_p_ca = $signed(i_cfg.col_gain_a) * $signed(i_byte_a);
    assign n_p_cb = $signed(i_cfg.col_gain_b) * $signed(i_byte_b);

    always_ff @(posedge i_clk) begin
        if (i_ld.s1) begin
            r_p_ra <= n_p_ra;
            r_p_rb <= n_p_rb;
            r_p_ca <= n_p_ca;
            r_p_cb <= n_p_cb;
        end
    end

    // stage 2: sums with offsets
    logic signed [SUM_W-1:0] n_s_row, n_s_col, r_s_row, r_s_col;

    assign n_s_row = SUM_W'(r_p_ra) + SUM_W'(r_p_rb) + SUM_W'($signed(i_cfg.row_offset));
    assign n_s_col = SUM_W'(r_p_ca) + SUM_W'(r_p_cb) + SUM_W'($signed(i_cfg.col_offset));

    always_ff @(posedge i_clk) begin
        if (i_ld.s2) begin
            r_s_row <= n_s_row;
            r_s_col <= n_s_col;
        end
    end

    // stage 3: divide by 256 toward zero, sign and column checks
    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'((1 << FIXED_SHIFT) - 1);

    logic signed [SUM_W-1:0] w_t_row, w_t_col;
    logic [Q_W-1:0]          w_q_row, w_q_col;
    logic [RC_W-1:0]         n_r3, n_c3, r_r3, r_c3;
    logic                    n_bad3, r_bad3;

    assign w_t_row = r_s_row + (r_s_row[SUM_W-1] ? ROUND_BIAS : '0);
    assign w_t_col = r_s_col + (r_s_col[SUM_W-1] ? ROUND_BIAS : '0);
    assign w_q_row = w_t_row[SUM_W-1:FIXED_SHIFT];
    assign w_q_col = w_t_col[SUM_W-1:FIXED_SHIFT];
    assign n_r3    = w_q_row[RC_W-1:0];
    assign n_c3    = w_q_col[RC_W-1:0];
    assign n_bad3  = w_q_row[Q_W-1] | w_q_col[Q_W-1]
                   | (w_q_col[RC_W-1:0] >= RC_W'(i_cfg.row_pitch));

    always_ff @(posedge i_clk) begin
        if (i_ld.s3) begin
            r_r3   <= n_r3;
            r_c3   <= n_c3;
            r_bad3 <= n_bad3;
        end
    end

    // stage 4: row times pitch
    logic [RP_W-1:0] n_prod4, r_prod4;
    logic [RC_W-1:0] r_c4;
    logic            r_bad4;

    assign n_prod4 = RP_W'(r_r3) * RP_W'(i_cfg.row_pitch);

    always_ff @(posedge i_clk) begin
        if (i_ld.s4) begin
            r_prod4 <= n_prod4;
            r_c4    <= r_c3;
            r_bad4  <= r_bad3;
        end
    end

    // stage 5: address and store bound
    logic [AD_W-1:0] w_ad;
    logic [AW-1:0]   r_addr5;
    logic            n_oor5, r_oor5;

    assign w_ad   = AD_W'(r_prod4) + AD_W'(r_c4);
    assign n_oor5 = r_bad4 | (w_ad >= AD_W'(IMAGE_WORDS));

    always_ff @(posedge i_clk) begin
        if (i_ld.s5) begin
            r_addr5 <= w_ad[AW-1:0];
            r_oor5  <= n_oor5;
        end
    end

    assign o_addr = r_addr5;
    assign o_oor  = r_oor5;

endmodule

// ===== rtl/apbt_store.sv =====
// grayscale pixel store: one write port, two registered read ports
// depends on apbt_pkg
module apbt_store import apbt_pkg::*; #(
    parameter  int IMAGE_WORDS = IMAGE_WORDS_DEF,
    localparam int AW          = $clog2(IMAGE_WORDS)
) (
    input  logic               i_clk,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr_a,
    input  logic [AW-1:0]      i_rd_addr_b,
    input  logic               i_wr_en,
    input  logic [WADDR_W-1:0] i_wr_addr,
    input  logic [PIX_W-1:0]   i_wr_data,
    output logic [PIX_W-1:0]   o_rd_data_a,
    output logic [PIX_W-1:0]   o_rd_data_b
);

    localparam int WIDE_W = 25;

    logic [PIX_W-1:0]  r_mem [IMAGE_WORDS];
    logic [PIX_W-1:0]  r_rd_a, r_rd_b;
    logic [WIDE_W-1:0] w_wr_wide;
    logic              w_wr_ok;

    // writes beyond the store are dropped
    assign w_wr_wide = WIDE_W'(i_wr_addr);
    assign w_wr_ok   = w_wr_wide < WIDE_W'(IMAGE_WORDS);

    always_ff @(posedge i_clk) begin
        if (i_wr_en && w_wr_ok) begin
            r_mem[w_wr_wide[AW-1:0]] <= i_wr_data;
        end
    end

    // both test points read in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== rtl/affine_pixel_pair_binary_test_top.sv =====
// top level of the affine pixel-pair binary test block
// depends on apbt_pkg, apbt_ifs, apbt_cfg, apbt_point_map and apbt_store
//
// The block takes one item per clock while a stage is free or the result is
// taken, writes and tests mixed freely. A test returns its result through the
// final result register; a write returns nothing and lands in the pixel store
// as it leaves the address stage, ahead of every later test. The pace is set
// by the seven-stage pipeline: gain multipliers, offset sums, truncating
// divide with column check, row-pitch multiplier, address bound, a store with
// two read ports so that both pixels of a test are fetched in the same cycle,
// and the threshold compare. Bubbles close up under back-pressure; a waiting
// result stalls the input only once every stage is full. Pixels never written
// read as anything. Configuration, written on its own always-ready channel, is
// not guarded: the user must write it only while the block has no item in flight.
module affine_pixel_pair_binary_test_top import apbt_pkg::*; #(
    parameter int IMAGE_WORDS = IMAGE_WORDS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    apbt_item_if.sink     i_item,
    apbt_result_if.source o_result,
    apbt_cfg_if.sink      i_cfg
);

    localparam int AW     = $clog2(IMAGE_WORDS);
    localparam int STAGES = 7;

    t_cfg    w_cfg;
    t_map_ld w_map_ld;

    logic [STAGES:1] r_v, n_v;
    logic [STAGES:1] w_rdy;

    apbt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // per-stage ready, a stage loads when empty or when it moves on
    always_comb begin
        w_rdy[STAGES] = !r_v[STAGES] || o_result.ready;
        for (int k = STAGES - 1; k >= 1; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign i_item.ready = w_rdy[1];
    assign w_map_ld     = '{s1: w_rdy[1], s2: w_rdy[2], s3: w_rdy[3],
                            s4: w_rdy[4], s5: w_rdy[5]};

    // write beats travel with the tests up to the store stage
    t_wr_beat r_wr [1:5];

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_wr[1] <= '{action: i_item.action, addr: i_item.pixel_address,
                         value: i_item.pixel_value};
        end
        for (int k = 2; k <= 5; k++) begin
            if (w_rdy[k]) begin
                r_wr[k] <= r_wr[k-1];
            end
        end
    end

    // valid bits; writes leave the pipeline at the store stage
    always_comb begin
        n_v = r_v;
        if (w_rdy[1]) n_v[1] = i_item.valid;
        for (int k = 2; k <= 5; k++) begin
            if (w_rdy[k]) n_v[k] = r_v[k-1];
        end
        if (w_rdy[6]) n_v[6] = r_v[5] && (r_wr[5].action == ACTION_TEST);
        if (w_rdy[7]) n_v[7] = r_v[6];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    // coordinate mapping of both points
    logic [AW-1:0] w_addr_1, w_addr_2;
    logic          w_oor_1, w_oor_2;

    apbt_point_map #(.IMAGE_WORDS(IMAGE_WORDS)) u_map_1 (
        .i_clk    (i_clk),
        .i_ld     (w_map_ld),
        .i_cfg    (w_cfg),
        .i_byte_a (i_item.test_code[7:0]),
        .i_byte_b (i_item.test_code[15:8]),
        .o_addr   (w_addr_1),
        .o_oor    (w_oor_1)
    );

    apbt_point_map #(.IMAGE_WORDS(IMAGE_WORDS)) u_map_2 (
        .i_clk    (i_clk),
        .i_ld     (w_map_ld),
        .i_cfg    (w_cfg),
        .i_byte_a (i_item.test_code[23:16]),
        .i_byte_b (i_item.test_code[31:24]),
        .o_addr   (w_addr_2),
        .o_oor    (w_oor_2)
    );

    // pixel store, written and read as beats leave the address stage
    logic [PIX_W-1:0] w_pix_1, w_pix_2;
    logic             w_wr_en;

    assign w_wr_en = w_rdy[6] && r_v[5] && (r_wr[5].action == ACTION_WRITE);

    apbt_store #(.IMAGE_WORDS(IMAGE_WORDS)) u_store (
        .i_clk       (i_clk),
        .i_rd_en     (w_rdy[6]),
        .i_rd_addr_a (w_addr_1),
        .i_rd_addr_b (w_addr_2),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (r_wr[5].addr),
        .i_wr_data   (r_wr[5].value),
        .o_rd_data_a (w_pix_1),
        .o_rd_data_b (w_pix_2)
    );

    logic r_oor6;

    always_ff @(posedge i_clk) begin
        if (w_rdy[6]) begin
            r_oor6 <= w_oor_1 | w_oor_2;
        end
    end

    // absolute difference against threshold, result register
    logic [PIX_W-1:0] w_abs;
    logic             n_res7, r_res7, r_oor7;

    assign w_abs  = (w_pix_1 >= w_pix_2) ? (w_pix_1 - w_pix_2) : (w_pix_2 - w_pix_1);
    assign n_res7 = !r_oor6 && (w_abs > w_cfg.threshold);

    always_ff @(posedge i_clk) begin
        if (w_rdy[7]) begin
            r_res7 <= n_res7;
            r_oor7 <= r_oor6;
        end
    end

    assign o_result.valid        = r_v[STAGES];
    assign o_result.test_result  = r_res7;
    assign o_result.out_of_range = r_oor7;

endmodule

// ===== dv/tb_affine_pixel_pair_binary_test_top.sv =====
// testbench for the affine pixel-pair binary test block: random and directed pixel writes
// and tests, each result checked against an in-bench predictor of the coordinate mapping
// depends on apbt_pkg, apbt_ifs and affine_pixel_pair_binary_test_top
module tb_affine_pixel_pair_binary_test_top;
    timeunit 1ns;
    timeprecision 1ps;
    import apbt_pkg::*;

    localparam int     PHASES           = 12;
    localparam int     TAIL_CYCLES      = 16;
    localparam int     RECV_HOLD_CYCLES = 400;
    localparam int     LIMIT_CYCLES     = 200000;
    localparam longint FIXED_SCALE      = longint'(1) << FIXED_SHIFT;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(REG_ROW_PITCH) + 1'b1;

    typedef struct {
        logic               action;
        logic [WADDR_W-1:0] addr;
        logic [PIX_W-1:0]   value;
        logic [CODE_W-1:0]  code;
    } t_pixel_item;

    typedef struct packed {
        logic test_result;
        logic out_of_range;
    } t_pair_verdict;

    logic i_clk;
    logic i_rst_n;

    apbt_item_if   item_bus ();
    apbt_result_if result_bus ();
    apbt_cfg_if    cfg_bus ();

    affine_pixel_pair_binary_test_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus),
        .i_cfg    (cfg_bus)
    );

    // predictor state: configuration and pixel store as the block should hold them
    t_cfg             cfg_model;
    logic [PIX_W-1:0] pixel_model [IMAGE_WORDS_DEF];
    // pixels that some queued write has already loaded
    bit               pixel_loaded [IMAGE_WORDS_DEF];

    t_pixel_item   pending_items [$];
    t_pixel_item   offered_item;
    t_pair_verdict expected_verdicts [$];

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_request  = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;
    int          error_count   = 0;
    int unsigned cycle_count   = 0;

    // clock and reset
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // maps one point to a store address, -1 when it falls outside the row or the store
    function automatic longint point_address(t_cfg c, logic signed [PIX_W-1:0] a,
                                             logic signed [PIX_W-1:0] b);
        longint row;
        longint col;
        longint lin;
        row = (longint'(c.row_gain_a) * a + longint'(c.row_gain_b) * b
               + longint'(c.row_offset)) / FIXED_SCALE;
        col = (longint'(c.col_gain_a) * a + longint'(c.col_gain_b) * b
               + longint'(c.col_offset)) / FIXED_SCALE;
        if (row < 0 || col < 0 || col >= longint'(c.row_pitch)) return -1;
        lin = row * longint'(c.row_pitch) + col;
        if (lin >= IMAGE_WORDS_DEF) return -1;
        return lin;
    endfunction

    // updates the store on a write, expects a verdict on a test
    function automatic void predict_pair_test(t_pixel_item it);
        longint        p1;
        longint        p2;
        int            diff;
        t_pair_verdict v;
        if (it.action == ACTION_WRITE) begin
            if (it.addr < IMAGE_WORDS_DEF) pixel_model[it.addr] = it.value;
            return;
        end
        p1 = point_address(cfg_model, it.code[7:0], it.code[15:8]);
        p2 = point_address(cfg_model, it.code[23:16], it.code[31:24]);
        if (p1 < 0 || p2 < 0) begin
            v = '{test_result: 1'b0, out_of_range: 1'b1};
        end else begin
            diff = int'(pixel_model[p1]) - int'(pixel_model[p2]);
            if (diff < 0) diff = -diff;
            v = '{test_result: diff > int'(cfg_model.threshold), out_of_range: 1'b0};
        end
        expected_verdicts.push_back(v);
    endfunction

    function automatic int rand_span(int lo, int hi);
        return int'($urandom_range(hi - lo)) + lo;
    endfunction

    function automatic logic [CODE_W-1:0] make_code(int a1, int b1, int a2, int b2);
        return {8'(b2), 8'(a2), 8'(b1), 8'(a1)};
    endfunction

    task automatic queue_write(logic [WADDR_W-1:0] addr, logic [PIX_W-1:0] value);
        t_pixel_item it;
        it = '{action: ACTION_WRITE, addr: addr, value: value, code: $urandom};
        pending_items.push_back(it);
        pixel_loaded[addr] = 1'b1;
    endtask

    // a test first loads any pixel it reads that was never written
    task automatic queue_test(logic [CODE_W-1:0] code);
        longint      p1;
        longint      p2;
        t_pixel_item it;
        p1 = point_address(cfg_model, code[7:0], code[15:8]);
        p2 = point_address(cfg_model, code[23:16], code[31:24]);
        if (p1 >= 0 && !pixel_loaded[p1]) queue_write(WADDR_W'(p1), 8'($urandom));
        if (p2 >= 0 && !pixel_loaded[p2]) queue_write(WADDR_W'(p2), 8'($urandom));
        it = '{action: ACTION_TEST, addr: 16'($urandom), value: 8'($urandom), code: code};
        pending_items.push_back(it);
    endtask

    // writes and tests, half of the tests on points near the origin of the code space
    task automatic queue_random(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 30) begin
                queue_write(16'($urandom), 8'($urandom));
            end else if ($urandom_range(1) == 0) begin
                queue_test($urandom);
            end else begin
                queue_test(make_code(rand_span(-8, 7), rand_span(-8, 7),
                                     rand_span(-8, 7), rand_span(-8, 7)));
            end
        end
    endtask

    // one register write beat; the model follows once it is accepted
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        cfg_bus.valid <= 1'b0;
        case (idx)
            REG_THRESHOLD:  cfg_model.threshold  = data[PIX_W-1:0];
            REG_ROW_GAIN_A: cfg_model.row_gain_a = data;
            REG_ROW_GAIN_B: cfg_model.row_gain_b = data;
            REG_ROW_OFFSET: cfg_model.row_offset = data;
            REG_COL_GAIN_A: cfg_model.col_gain_a = data;
            REG_COL_GAIN_B: cfg_model.col_gain_b = data;
            REG_COL_OFFSET: cfg_model.col_offset = data;
            REG_ROW_PITCH:  cfg_model.row_pitch  = data[PITCH_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // unused upper data bits of the narrow registers carry noise
    task automatic apply_cfg(int thr, int rga, int rgb, int roff, int cga, int cgb,
                             int coff, int pitch);
        write_reg(REG_THRESHOLD, {16'($urandom), 8'(thr)});
        write_reg(REG_ROW_GAIN_A, CFG_DATA_W'(rga));
        write_reg(REG_ROW_GAIN_B, CFG_DATA_W'(rgb));
        write_reg(REG_ROW_OFFSET, CFG_DATA_W'(roff));
        write_reg(REG_COL_GAIN_A, CFG_DATA_W'(cga));
        write_reg(REG_COL_GAIN_B, CFG_DATA_W'(cgb));
        write_reg(REG_COL_OFFSET, CFG_DATA_W'(coff));
        write_reg(REG_ROW_PITCH, {11'($urandom), 13'(pitch)});
    endtask

    // block idle: every item taken, every verdict back, pipeline flushed
    task automatic wait_drained();
        while (pending_items.size() != 0 || item_bus.valid || expected_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    // known levels on every input from time zero
    initial begin
        item_bus.valid         = 1'b0;
        item_bus.action        = ACTION_WRITE;
        item_bus.pixel_address = '0;
        item_bus.pixel_value   = '0;
        item_bus.test_code     = '0;
        result_bus.ready       = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = '0;
        cfg_bus.data           = '0;
        cfg_model              = '0;
        cfg_model.row_pitch    = ROW_PITCH_RESET;
    end

    // item driver: holds a beat until taken, then offers the next one or idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_bus.valid <= 1'b0;
        end else if (!item_bus.valid || item_bus.ready) begin
            if (item_bus.valid) begin
                predict_pair_test(offered_item);
            end
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                offered_item = pending_items.pop_front();
                item_bus.valid         <= 1'b1;
                item_bus.action        <= offered_item.action;
                item_bus.pixel_address <= offered_item.addr;
                item_bus.pixel_value   <= offered_item.value;
                item_bus.test_code     <= offered_item.code;
            end else begin
                item_bus.valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver back-pressure, with an occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
        end else begin
            if (result_bus.valid && result_bus.ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result beat with no test pending: test_result %0b out_of_range %0b",
                           result_bus.test_result, result_bus.out_of_range);
                    error_count++;
                end else begin
                    if (result_bus.test_result !== expected_verdicts[0].test_result) begin
                        $error("test_result: expected %0b, actual %0b",
                               expected_verdicts[0].test_result, result_bus.test_result);
                        error_count++;
                    end
                    if (result_bus.out_of_range !== expected_verdicts[0].out_of_range) begin
                        $error("out_of_range: expected %0b, actual %0b",
                               expected_verdicts[0].out_of_range, result_bus.out_of_range);
                        error_count++;
                    end
                    void'(expected_verdicts.pop_front());
                end
            end
            if (hold_served != hold_request) begin
                hold_served = hold_request;
                hold_left   = RECV_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end else begin
                result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // stimulus: one register setting per phase, idling pattern changes every four phases
    initial begin
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph / 4)
                0: begin
                    send_idle_pct = 30;
                    recv_idle_pct = 68;
                end
                1: begin
                    send_idle_pct = 68;
                    recv_idle_pct = 30;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (ph)
                0: begin
                    // row = a + 128, col = b + 128 over a 256 wide image
                    apply_cfg(10, 256, 0, 32768, 0, 256, 32768, 256);
                    queue_write(16'h0000, 8'h00);
                    queue_write(16'hFFFF, 8'hFF);
                    queue_test(make_code(-128, -128, 127, 127));
                    queue_test(make_code(127, 127, -128, -128));
                    queue_test(make_code(-128, -128, -128, -128));
                    // differences just at and just above the threshold
                    queue_write(16'h8080, 8'd100);
                    queue_write(16'h8081, 8'd110);
                    queue_write(16'h8180, 8'd111);
                    queue_test(make_code(0, 0, 0, 1));
                    queue_test(make_code(0, 0, 1, 0));
                    queue_test(make_code(1, 0, 0, 0));
                    queue_write(16'hAAAA, 8'h55);
                    queue_write(16'h5555, 8'hAA);
                    queue_test(32'h55AA_AA55);
                    queue_test(32'hFFFF_FFFF);
                    queue_test(32'h0000_0000);
                end
                1: begin
                    apply_cfg(rand_span(0, 40), 256, 0, 32768, 0, 256, 32768, 256);
                    queue_random(140);
                    hold_request++;
                end
                2: begin
                    // row = a, col = b + 8, pitch 128
                    apply_cfg(0, 256, 0, 0, 0, 256, 2048, 128);
                    queue_test(make_code(-1, 0, 0, 0));
                    queue_test(make_code(0, 120, 0, 0));
                    queue_test(make_code(0, -9, 0, 0));
                    queue_test(make_code(5, 5, 6, 6));
                    queue_test(make_code(127, 119, 0, -8));
                    queue_random(70);
                    // sender pause until all verdicts are back
                    wait_drained();
                    queue_random(70);
                end
                3: begin
                    apply_cfg(255, 64, 32, 8192, 16, -48, 1024, 4096);
                    queue_random(100);
                end
                4: begin
                    // zero pitch: everything out of the row
                    apply_cfg(rand_span(0, 255), 256, 0, 32768, 0, 256, 32768, 0);
                    queue_random(60);
                end
                5: begin
                    apply_cfg(255, -8388608, 8388607, -8388608, 8388607, -8388608, 8388607,
                              8191);
                    // indexes past the last register are ignored
                    for (int k = REG_SPARE_FIRST; k < (1 << CFG_IDX_W); k++)
                        write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
                    queue_random(60);
                end
                6: begin
                    // pitch 1 with a small negative column offset that truncates to zero
                    apply_cfg(rand_span(0, 255), -300, 200, 40000, 0, 0, -255, 1);
                    queue_test(make_code(127, -10, 0, 0));
                    queue_random(100);
                end
                10: begin
                    apply_cfg(0, 8388607, -8388608, 8388607, -8388608, 8388607, -8388608,
                              4096);
                    queue_random(60);
                end
                11: begin
                    apply_cfg(rand_span(0, 255), 256, 0, 32768, 0, 256, 32768, 256);
                    queue_random(160);
                end
                default: begin
                    apply_cfg(rand_span(0, 255), rand_span(-512, 512), rand_span(-512, 512),
                              rand_span(-16384, 49152), rand_span(-512, 512),
                              rand_span(-512, 512), rand_span(-16384, 49152),
                              rand_span(1, 300));
                    queue_random(140);
                end
            endcase
        end
        wait_drained();
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
